### sv/assert_macros.svh
// Assertion macros shared by the sanitizer RTL.
// No dependencies; the macro bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define USF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sanitizer assertion failed");
`define USF_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("sanitizer forbidden condition seen");
`else
`define USF_ASSERT(lbl, clk, rstn, prop)
`define USF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### sv/usf_pkg.sv
// Types, constants and byte classification functions for the UTF-8 sanitizer.
// No dependencies; used by every module of the block.
package usf_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] SUB_RESET = 8'h3F;
    localparam logic [7:0] ASCII_DEL = 8'h7F;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;

    localparam logic [2:0] LEN_STRAY = 3'd0;
    localparam logic [2:0] LEN_ASCII = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [10:0] CP_C1_MAX      = 11'h09F;
    localparam logic [10:0] CP_SOFT_HYPHEN = 11'h0AD;
    localparam logic [10:0] CP_COMB_LO     = 11'h300;
    localparam logic [10:0] CP_COMB_HI     = 11'h36F;
    localparam logic [10:0] CP_ARAB_LO     = 11'h600;
    localparam logic [10:0] CP_ARAB_HI     = 11'h605;
    localparam logic [10:0] CP_ALM         = 11'h61C;
    localparam logic [10:0] CP_AYAH        = 11'h6DD;
    localparam logic [10:0] CP_SAM         = 11'h70F;

    // One decided run of bytes, oldest in bytes[0]
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
        logic            last;
    } group_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)
            len = LEN_ASCII;
        else if ((b & 8'hE0) == 8'hC0)
            len = LEN_TWO;
        else if ((b & 8'hF0) == 8'hE0)
            len = LEN_THREE;
        else if ((b & 8'hF8) == 8'hF0)
            len = LEN_FOUR;
        else
            len = LEN_STRAY;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic is_ctrl(input logic [7:0] b);
        return (b <= CTRL_MAX) || (b == ASCII_DEL);
    endfunction

    function automatic logic two_byte_rejected(input logic [7:0] lead, input logic [7:0] c1);
        logic [10:0] cp;
        cp = {lead[4:0], c1[5:0]};
        return (cp <= CP_C1_MAX) || (cp == CP_SOFT_HYPHEN)
            || ((cp >= CP_COMB_LO) && (cp <= CP_COMB_HI))
            || ((cp >= CP_ARAB_LO) && (cp <= CP_ARAB_HI))
            || (cp == CP_ALM) || (cp == CP_AYAH) || (cp == CP_SAM);
    endfunction

endpackage

### sv/usf_front.sv
// Front end: accepts bytes, holds undecided sequences and decides each byte.
// Depends on usf_pkg and assert_macros.svh; pushes decided runs to usf_queue.
`include "assert_macros.svh"

module usf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic [7:0]         sub_byte,
    input  logic               full,
    output logic               push,
    output usf_pkg::group_t    push_data
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] pend_reg  [3];
    logic [7:0] pend_next [3];
    logic [7:0] win [4];
    logic [7:0] val [4];
    logic [2:0] n;
    logic [2:0] k;
    logic       accept;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;
    assign n        = {1'b0, cnt_reg} + 3'd1;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            win[j] = (2'(j) < cnt_reg) ? pend_reg[j] : in_byte;
        end
        win[3] = in_byte;
    end

    // Scan the window from the oldest byte; decided bytes form a prefix
    always_comb
    begin
        logic [1:0] skip;
        logic       stop;
        logic       flush;
        logic       rep;
        logic       bad;
        logic [2:0] t;
        logic [2:0] r;
        skip  = 2'd0;
        stop  = 1'b0;
        flush = 1'b0;
        rep   = 1'b0;
        bad   = 1'b0;
        t     = usf_pkg::LEN_STRAY;
        r     = 3'd0;
        k     = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            val[i] = win[i];
            if ((3'(i) < n) && !stop)
            begin
                if (skip != 2'd0)
                begin
                    skip   = skip - 2'd1;
                    val[i] = rep ? sub_byte : win[i];
                    k      = k + 3'd1;
                end
                else if (flush)
                begin
                    val[i] = sub_byte;
                    k      = k + 3'd1;
                end
                else
                begin
                    t = usf_pkg::lead_length(win[i]);
                    r = n - 3'(i);
                    if (t == usf_pkg::LEN_STRAY)
                    begin
                        val[i] = sub_byte;
                        k      = k + 3'd1;
                    end
                    else if (t == usf_pkg::LEN_ASCII)
                    begin
                        val[i] = usf_pkg::is_ctrl(win[i]) ? sub_byte : win[i];
                        k      = k + 3'd1;
                    end
                    else if (in_last && (r < t))
                    begin
                        flush  = 1'b1;
                        val[i] = sub_byte;
                        k      = k + 3'd1;
                    end
                    else if (!in_last && (r < (t - 3'd1)))
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        bad = 1'b0;
                        for (int q = 1; q < 4; q++)
                        begin
                            if (((i + q) < 4) && (3'(q) < r) && (3'(q) < t)
                                && !usf_pkg::is_cont(win[2'(i + q)]))
                                bad = 1'b1;
                        end
                        if (bad)
                        begin
                            val[i] = sub_byte;
                            k      = k + 3'd1;
                        end
                        else if (r < t)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            if (i < 3)
                                rep = (t != usf_pkg::LEN_TWO)
                                    || usf_pkg::two_byte_rejected(win[i], win[2'(i + 1)]);
                            else
                                rep = 1'b1;
                            val[i] = rep ? sub_byte : win[i];
                            skip   = 2'(t - 3'd1);
                            k      = k + 3'd1;
                        end
                    end
                end
            end
        end
    end

    // Hold the undecided suffix
    always_comb
    begin
        cnt_next = 2'(n - k);
        for (int j = 0; j < 3; j++)
        begin
            pend_next[j] = pend_reg[j];
            for (int s = 0; s < 4; s++)
            begin
                if ((k == 3'(s)) && ((s + j) < 4))
                    pend_next[j] = win[2'(s + j)];
            end
        end
    end

    assign push = accept && (k != 3'd0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            push_data.bytes[i] = val[i];
        end
        push_data.cnt_m1 = 2'(k - 3'd1);
        push_data.last   = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pend_reg[j] <= pend_next[j];
            end
        end
    end

    `USF_ASSERT(a_last_empties_hold, clk, rst_n, (accept && in_last) |=> (cnt_reg == 2'd0))
    `USF_ASSERT(a_last_pushes_run, clk, rst_n, (accept && in_last) |-> push)

endmodule

### sv/usf_queue.sv
// Short queue of decided runs between the front and back ends.
// Depends on usf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  usf_pkg::group_t push_data,
    output logic            full,
    input  logic            pop,
    output usf_pkg::group_t head,
    output logic            empty
);

    usf_pkg::group_t                    entry_reg [usf_pkg::QDEPTH];
    logic [usf_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [usf_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [usf_pkg::QCNT_W-1:0]         count_reg;
    logic [usf_pkg::QCNT_W-1:0]         count_next;

    assign full  = (count_reg == usf_pkg::QCNT_W'(usf_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + usf_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - usf_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + usf_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + usf_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `USF_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full)
    `USF_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && empty)

endmodule

### sv/usf_back.sv
// Back end: sends the bytes of each queued run, one transfer per cycle while out_stall is low.
// Depends on usf_pkg and assert_macros.svh; reads the head of usf_queue.
`include "assert_macros.svh"

module usf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  usf_pkg::group_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            out_run_end,
    output logic            out_buffer_end
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       xfer;

    assign out_valid      = !empty;
    assign xfer           = out_valid && !out_stall;
    assign out_byte       = head.bytes[idx_reg];
    assign out_run_end    = (idx_reg == head.cnt_m1);
    assign out_buffer_end = out_run_end && head.last;
    assign pop            = xfer && out_run_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
            idx_next = out_run_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

    `USF_ASSERT(a_idx_in_run, clk, rst_n, !empty |-> (idx_reg <= head.cnt_m1))

endmodule

### sv/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer: substitute register and the
// front end, run queue and back end. Depends on usf_pkg, usf_front, usf_queue, usf_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | in_byte, in_last
//  output   | out_valid/out_stall | out_byte, out_run_end, out_buffer_end
//  config   | cfg_valid/cfg_ready | substitute_byte
//
// One byte is taken per cycle while the four-entry run queue has room; each
// accepted byte is decided in the cycle it arrives or held (at most three).
// The back end sends one byte per cycle while out_stall is low, and the output
// port sets the sustained rate of one byte per cycle.
// Reset clears the hold count, queue and substitute (to '?'); no clearing pass.
// An output stall fills the queue, after which in_stall rises.
module utf8_stream_sanitizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_run_end,
    output logic       out_buffer_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] substitute_byte
);

    logic [7:0]      sub_reg;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    usf_pkg::group_t push_data;
    usf_pkg::group_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= usf_pkg::SUB_RESET;
        else if (cfg_valid && cfg_ready)
            sub_reg <= substitute_byte;
    end

    usf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .sub_byte  (sub_reg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    usf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    usf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_run_end    (out_run_end),
        .out_buffer_end (out_buffer_end)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for utf8_stream_sanitizer: directed table, then random UTF-8 traffic
// checked against a byte-level predictor, with random idling on both channels.
// Depends on the RTL (usf_pkg and utf8_stream_sanitizer) only.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       buf_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0]      data;
        logic            last;
        logic            known;
        logic [2:0]      count;
        logic [3:0][7:0] res;
    } stim_row_t;

    localparam int N_DIRECTED   = 24;
    localparam int N_PHASE      = 99;
    localparam int DRAIN_CYCLES = 16;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        {8'h41, 1'b0, 1'b1, 3'd1, 32'h0000_0041},
        {8'h00, 1'b0, 1'b1, 3'd1, 32'h0000_003F},
        {8'h7F, 1'b0, 1'b1, 3'd1, 32'h0000_003F},
        {8'h80, 1'b0, 1'b1, 3'd1, 32'h0000_003F},
        {8'hFF, 1'b0, 1'b1, 3'd1, 32'h0000_003F},
        {8'hC3, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
        {8'hA9, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hC2, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hAD, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hE2, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h82, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hAC, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hF0, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h9F, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h98, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h80, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hC3, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h41, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hF0, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h90, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'h41, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        {8'hE2, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
        {8'h82, 1'b1, 1'b1, 3'd2, 32'h0000_3F3F},
        {8'hC3, 1'b1, 1'b1, 3'd1, 32'h0000_003F}
    };

    // Two-byte pairs on and around the rejected code point ranges
    localparam logic [15:0] EDGE_PAIRS [14] = '{
        16'hC280, 16'hC29F, 16'hC2A0, 16'hC2AD, 16'hC2AE, 16'hCC80, 16'hCDAF,
        16'hCDB0, 16'hD880, 16'hD885, 16'hD886, 16'hD89C, 16'hDB9D, 16'hDC8F
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_buffer_end;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] substitute_byte = 8'h00;

    logic [7:0] held_bytes [3];
    int         held_count = 0;
    logic [7:0] sub_now = 8'h3F;

    out_item_t  expected_out [$];
    out_item_t  head;
    logic [7:0] seq_q [$];

    int mismatches = 0;
    int bytes_in = 0;
    int bytes_out = 0;
    int buffers = 0;
    int settings = 0;
    int gap_odds = 6;
    int stall_odds = 5;
    int stall_left = 0;

    utf8_stream_sanitizer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_run_end    (out_run_end),
        .out_buffer_end (out_buffer_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .substitute_byte(substitute_byte)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int seq_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic logic cp_rejected(input logic [10:0] cp);
        return (cp < 11'h0A0) || (cp == 11'h0AD)
            || (cp >= 11'h300 && cp <= 11'h36F)
            || (cp >= 11'h600 && cp <= 11'h605)
            || (cp == 11'h61C) || (cp == 11'h6DD) || (cp == 11'h70F);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic sanitize_predict(input logic [7:0] b, input logic last,
                                    output int n, output logic [3:0][7:0] res);
        logic [7:0] win [4];
        int         cnt;
        int         pos;
        int         need;
        int         left;
        int         q;
        logic       bad;
        logic       done;
        cnt = 0;
        n = 0;
        pos = 0;
        done = 1'b0;
        res = '0;
        for (q = 0; q < held_count; q++)
        begin
            win[cnt] = held_bytes[q];
            cnt++;
        end
        win[cnt] = b;
        cnt++;
        while (pos < cnt && !done)
        begin
            need = seq_len(win[pos]);
            left = cnt - pos;
            if (need == 0)
            begin
                res[n] = sub_now;
                n++;
                pos++;
            end
            else if (need == 1)
            begin
                res[n] = (win[pos] <= 8'h1F || win[pos] == 8'h7F) ? sub_now : win[pos];
                n++;
                pos++;
            end
            else if (last && left < need)
            begin
                while (pos < cnt)
                begin
                    res[n] = sub_now;
                    n++;
                    pos++;
                end
            end
            else if (!last && left < need - 1)
                done = 1'b1;
            else
            begin
                bad = 1'b0;
                for (q = 1; q < need && q < left; q++)
                    if (win[pos + q][7:6] != 2'b10)
                        bad = 1'b1;
                if (bad)
                begin
                    res[n] = sub_now;
                    n++;
                    pos++;
                end
                else if (left < need)
                    done = 1'b1;
                else if (need == 2)
                begin
                    if (cp_rejected({win[pos][4:0], win[pos + 1][5:0]}))
                    begin
                        res[n] = sub_now;
                        res[n + 1] = sub_now;
                    end
                    else
                    begin
                        res[n] = win[pos];
                        res[n + 1] = win[pos + 1];
                    end
                    n += 2;
                    pos += 2;
                end
                else
                begin
                    for (q = 0; q < need; q++)
                    begin
                        res[n] = sub_now;
                        n++;
                    end
                    pos += need;
                end
            end
        end
        held_count = 0;
        while (pos < cnt && held_count < 3)
        begin
            held_bytes[held_count] = win[pos];
            held_count++;
            pos++;
        end
    endtask

    task automatic queue_results(input int n, input logic [3:0][7:0] res, input logic last);
        int i;
        for (i = 0; i < n; i++)
            expected_out.push_back('{res[i], i == n - 1, last && (i == n - 1)});
        if (last)
            buffers++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             output int n, output logic [3:0][7:0] res);
        in_byte <= b;
        in_last <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sanitize_predict(b, last, n, res);
        bytes_in++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_substitute(input logic [7:0] v);
        drain_results();
        substitute_byte <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sub_now = v;
        settings++;
    endtask

    task automatic fill_sequence();
        int         kind;
        int         conts;
        int         q;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            seq_q.push_back(8'($urandom_range(0, 127)));
        else if (kind < 50)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                q = $urandom_range(0, 13);
                seq_q.push_back(EDGE_PAIRS[q][15:8]);
                seq_q.push_back(EDGE_PAIRS[q][7:0]);
            end
            else
            begin
                seq_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                seq_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end
        else if (kind < 77)
        begin
            conts = (kind < 65) ? 2 : 3;
            lead = (conts == 2) ? (8'hE0 | 8'($urandom_range(0, 15)))
                                : (8'hF0 | 8'($urandom_range(0, 7)));
            seq_q.push_back(lead);
            for (q = 0; q < conts; q++)
                seq_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        else if (kind < 88)
        begin
            // break a sequence: too few continuations, then a non-continuation
            conts = $urandom_range(2, 4);
            lead = (conts == 2) ? 8'hC0 : (conts == 3) ? 8'hE0 : 8'hF0;
            seq_q.push_back(lead | 8'($urandom_range(0, 7)));
            for (q = 1; q < conts - 1 - int'($urandom_range(0, conts - 2)); q++)
                seq_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
            seq_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(192, 255)));
        end
        else
            seq_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int count, input int pressure_at);
        int              i;
        int              n;
        logic [3:0][7:0] res;
        logic [7:0]      b;
        logic            last;
        for (i = 0; i < count; i++)
        begin
            if (seq_q.size() == 0)
                fill_sequence();
            b = seq_q.pop_front();
            last = (i == count - 1) || ($urandom_range(0, 15) == 0);
            send_byte(b, last, n, res);
            queue_results(n, res, last);
            if (i == pressure_at)
                drain_results();
            else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
        seq_q.delete();
    endtask

    always @(posedge clk)
    begin
        if (stall_odds == 0)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= (stall_left > 1);
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(1, stall_odds) == 1)
        begin
            stall_left = $urandom_range(1, 19);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_out.size() == 0)
                report_mismatch("unexpected out_byte", out_byte, 0);
            else
            begin
                head = expected_out.pop_front();
                if (out_byte !== head.data)
                    report_mismatch("out_byte", out_byte, head.data);
                if (out_run_end !== head.run_end)
                    report_mismatch("out_run_end", out_run_end, head.run_end);
                if (out_buffer_end !== head.buf_end)
                    report_mismatch("out_buffer_end", out_buffer_end, head.buf_end);
                bytes_out++;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Timeout: run did not complete");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int              r;
        int              ph;
        int              n;
        logic [3:0][7:0] res;
        logic [7:0]      settings_list [4];
        settings_list[0] = 8'h00;
        settings_list[1] = 8'hFF;
        settings_list[2] = 8'($urandom_range(0, 255));
        settings_list[3] = 8'h7E;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_DIRECTED; r++)
        begin
            send_byte(DIRECTED[r].data, DIRECTED[r].last, n, res);
            if (DIRECTED[r].known)
                queue_results(int'(DIRECTED[r].count), DIRECTED[r].res, DIRECTED[r].last);
            else
                queue_results(n, res, DIRECTED[r].last);
            if ($urandom_range(1, gap_odds) == 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end

        for (ph = 0; ph < 4; ph++)
        begin
            write_substitute(settings_list[ph]);
            case (ph)
                0: begin gap_odds = 4; stall_odds = 4; end
                1: begin gap_odds = 0; stall_odds = 3; end
                2: begin gap_odds = 3; stall_odds = 0; end
                default: begin gap_odds = 0; stall_odds = 0; end
            endcase
            run_random(N_PHASE, (ph == 0) ? 50 : -1);
        end

        drain_results();
        $display("Sent %0d bytes in %0d buffers under %0d substitute settings plus reset value;",
                 bytes_in, buffers, settings);
        $display("checked %0d output transfers, %0d mismatches", bytes_out, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
